// ===== hw/rtl/min_heap_insert_delete_top_macros.svh =====
`ifndef MIN_HEAP_INSERT_DELETE_TOP_MACROS_SVH
`define MIN_HEAP_INSERT_DELETE_TOP_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define MHID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define MHID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mhid_pkg.sv =====
package mhid_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int COUNT_OUT_W  = 7;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]      root_value;
		logic        [COUNT_OUT_W-1:0] entry_count;
		logic                          is_empty;
		logic                          is_full;
		status_t                       status;
	} res_t;

endpackage

// ===== hw/rtl/mhid_if.sv =====
interface mhid_in_if;
	logic                              valid;
	logic                              ready;
	logic                              action;
	logic signed [mhid_pkg::DATA_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface mhid_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [mhid_pkg::DATA_W-1:0]      root_value;
	logic        [mhid_pkg::COUNT_OUT_W-1:0] entry_count;
	logic                                   is_empty;
	logic                                   is_full;
	mhid_pkg::status_t                      status;

	modport source (output valid, output root_value, output entry_count, output is_empty,
		output is_full, output status, input ready);
	modport sink   (input valid, input root_value, input entry_count, input is_empty,
		input is_full, input status, output ready);
endinterface

// ===== hw/rtl/mhid_ram.sv =====
module mhid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/mhid_ctrl.sv =====
`include "min_heap_insert_delete_top_macros.svh"

module mhid_ctrl #(
	parameter int CAPACITY = mhid_pkg::CAPACITY_DEF,
	parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mhid_in_if.sink                      in_item,
	output logic                         fin,
	output mhid_pkg::res_t               res,
	input  logic                         ack,
	output logic                         ram_we,
	output logic [AW-1:0]                ram_waddr,
	output logic [mhid_pkg::DATA_W-1:0]  ram_wdata,
	output logic                         ram_re,
	output logic [AW-1:0]                ram_raddr,
	input  logic [mhid_pkg::DATA_W-1:0]  ram_rdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;
	localparam int EW = (CW > mhid_pkg::COUNT_OUT_W) ? CW : mhid_pkg::COUNT_OUT_W;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_UP_RD  = 11'b000_0000_0010,
		S_UP_CMP = 11'b000_0000_0100,
		S_SRCH   = 11'b000_0000_1000,
		S_REM    = 11'b000_0001_0000,
		S_LAST   = 11'b000_0010_0000,
		S_DN_RL  = 11'b000_0100_0000,
		S_DN_RR  = 11'b000_1000_0000,
		S_DN_CMP = 11'b001_0000_0000,
		S_FIN    = 11'b010_0000_0000,
		S_SPARE  = 11'b100_0000_0000
	} state_t;

	state_t                             state_q;
	logic [CW-1:0]                      cnt_q;
	logic [CW-1:0]                      rd_idx_q;
	logic [AW-1:0]                      k_q;
	logic [AW-1:0]                      idx_s1;
	logic                               pend_s1;
	logic                               rvld_q;
	logic signed [mhid_pkg::DATA_W-1:0] val_q;
	logic signed [mhid_pkg::DATA_W-1:0] key_q;
	logic signed [mhid_pkg::DATA_W-1:0] lval_q;
	logic signed [mhid_pkg::DATA_W-1:0] root_q;
	mhid_pkg::status_t                  status_q;

	logic signed [mhid_pkg::DATA_W-1:0] rd_val;
	logic [AW-1:0]                      parent;
	logic [IW-1:0]                      l_w;
	logic [IW-1:0]                      r_w;
	logic [IW-1:0]                      n_ext;
	logic                               hit;
	logic                               take_r;
	logic signed [mhid_pkg::DATA_W-1:0] pval;
	logic [IW-1:0]                      pick;
	logic                               accept;
	logic [EW-1:0]                      cnt_ext;

	assign rd_val  = $signed(ram_rdata);
	assign parent  = AW'((k_q - 1'b1) >> 1);
	assign l_w     = {1'b0, k_q, 1'b1};
	assign r_w     = l_w + 1'b1;
	assign n_ext   = IW'(cnt_q);
	assign hit     = pend_s1 && (rd_val == key_q);
	assign take_r  = rvld_q && (rd_val < lval_q);
	assign pval    = take_r ? rd_val : lval_q;
	assign pick    = take_r ? r_w : l_w;
	assign accept  = in_item.valid && in_item.ready;
	assign cnt_ext = EW'(cnt_q);

	assign in_item.ready = (state_q == S_IDLE);
	assign fin           = (state_q == S_FIN);

	assign res.root_value  = (cnt_q != '0) ? root_q : '0;
	assign res.entry_count = cnt_ext[mhid_pkg::COUNT_OUT_W-1:0];
	assign res.is_empty    = (cnt_q == '0);
	assign res.is_full     = (cnt_q == CW'(CAPACITY));
	assign res.status      = status_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = parent;
		unique case (state_q)
			S_UP_RD: begin
				if (k_q == '0)
					ram_we = 1'b1;
				else
					ram_re = 1'b1;
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (val_q < rd_val)
					ram_wdata = rd_val;
			end
			S_SRCH: begin
				ram_re    = (rd_idx_q < cnt_q) && !hit;
				ram_raddr = rd_idx_q[AW-1:0];
			end
			S_REM: begin
				ram_re    = (CW'(k_q) != cnt_q);
				ram_raddr = cnt_q[AW-1:0];
			end
			S_DN_RL: begin
				ram_re    = (l_w < n_ext);
				ram_raddr = l_w[AW-1:0];
			end
			S_DN_RR: begin
				ram_re    = (r_w < n_ext);
				ram_raddr = r_w[AW-1:0];
			end
			S_DN_CMP: begin
				ram_we    = (pval < val_q);
				ram_wdata = pval;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
			rvld_q   <= 1'b0;
			status_q <= mhid_pkg::ST_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q    <= in_item.value;
						val_q    <= in_item.value;
						status_q <= mhid_pkg::ST_DONE;
						if (in_item.action == mhid_pkg::ACT_INSERT) begin
							if (cnt_q >= CW'(CAPACITY)) begin
								status_q <= mhid_pkg::ST_FULL;
								state_q  <= S_FIN;
							end else begin
								k_q     <= cnt_q[AW-1:0];
								cnt_q   <= cnt_q + 1'b1;
								state_q <= S_UP_RD;
							end
						end else begin
							rd_idx_q <= '0;
							pend_s1  <= 1'b0;
							state_q  <= S_SRCH;
						end
					end
				end
				S_UP_RD: begin
					state_q <= (k_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (val_q < rd_val) begin
						k_q     <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SRCH: begin
					pend_s1 <= ram_re;
					idx_s1  <= rd_idx_q[AW-1:0];
					if (ram_re)
						rd_idx_q <= rd_idx_q + 1'b1;
					if (hit) begin
						k_q     <= idx_s1;
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_REM;
					end else if (!pend_s1 && (rd_idx_q >= cnt_q)) begin
						status_q <= mhid_pkg::ST_MISS;
						state_q  <= S_FIN;
					end
				end
				S_REM: begin
					state_q <= (CW'(k_q) == cnt_q) ? S_FIN : S_LAST;
				end
				S_LAST: begin
					val_q   <= rd_val;
					state_q <= S_DN_RL;
				end
				S_DN_RL: begin
					state_q <= (l_w < n_ext) ? S_DN_RR : S_UP_RD;
				end
				S_DN_RR: begin
					lval_q  <= rd_val;
					rvld_q  <= (r_w < n_ext);
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (pval < val_q) begin
						k_q     <= pick[AW-1:0];
						state_q <= S_DN_RL;
					end else begin
						state_q <= S_UP_RD;
					end
				end
				S_FIN: begin
					if (ack)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// copy of the root entry, kept in step with every write to slot 0
	always_ff @(posedge clk) begin
		if (ram_we && (ram_waddr == '0))
			root_q <= $signed(ram_wdata);
	end

	`MHID_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY), "count above capacity")
	`MHID_ASSERT_IMP(a_wr_in_heap, clk, arst_n, ram_we, CW'(ram_waddr) < cnt_q, "write past last entry")
	`MHID_ASSERT_IMP(a_no_rw_clash, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr, "read and write hit one entry")
	`MHID_ASSERT_NXT(a_fin_hold, clk, arst_n, fin && !ack, fin && $stable(cnt_q), "result lost while stalled")

endmodule

// ===== hw/rtl/min_heap_insert_delete_top.sv =====
// Binary min-heap of signed 32-bit values, one item in flight at a time.
// Insert: a full heap answers with status FULL and is left unchanged; else the value sifts up from the new last slot.
// Remove: a linear search of the live entries (status MISS if absent), then the last entry fills the hole
// and sifts down, then up. The next item can be accepted in the cycle after the result is handed on.
// Reset clears the count and control; RAM contents are not cleared (only live entries are read).
module min_heap_insert_delete_top #(
	parameter int CAPACITY = mhid_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mhid_in_if.sink     in_item,
	mhid_out_if.source  out_item
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic                        fin;
	logic                        ack;
	mhid_pkg::res_t              res;
	mhid_pkg::res_t              out_q;
	logic                        out_vld_q;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [mhid_pkg::DATA_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [mhid_pkg::DATA_W-1:0] ram_rdata;

	mhid_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.fin       (fin),
		.res       (res),
		.ack       (ack),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	mhid_ram #(
		.WIDTH (mhid_pkg::DATA_W),
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ack = !out_vld_q || out_item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin && ack) begin
			out_vld_q <= 1'b1;
		end else if (out_item.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin && ack)
			out_q <= res;
	end

	assign out_item.valid       = out_vld_q;
	assign out_item.root_value  = out_q.root_value;
	assign out_item.entry_count = out_q.entry_count;
	assign out_item.is_empty    = out_q.is_empty;
	assign out_item.is_full     = out_q.is_full;
	assign out_item.status      = out_q.status;

endmodule
